[hw/rtl/boundary_tag_first_fit_allocator_core_macros.svh]
// Assertion macros shared by the checker of the allocator core.
// Needs nothing else; the checker file includes it by name.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BTFFA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define BTFFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/btffa_pkg.sv]
// Shared constants for the boundary tag first fit allocator.
// Depends on nothing; used by the core and its checker.
package btffa_pkg;

    localparam int KIND_W   = 2;
    localparam int REQ_W    = 24;
    localparam int OFF_W    = 17;
    localparam int WORD_W   = 17;
    localparam int SIZE_W   = 25;
    localparam int IN_TD_W  = 48;
    localparam int OUT_TD_W = 40;

    localparam int HDR_BYTES   = 16;
    localparam int FTR_BYTES   = 8;
    localparam int OVH_BYTES   = 24;
    localparam int SPLIT_MIN   = 32;
    localparam int ALIGN_ROUND = 7;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

endpackage

[hw/rtl/btffa_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module btffa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

[hw/rtl/btffa_alu.sv]
// Shared add/subtract unit of the allocator sequencer.
// Depends on nothing; the subtract also yields the unsigned compare.
module btffa_alu #(
    parameter int DW = 25
) (
    input  logic          i_sub,
    input  logic [DW-1:0] i_a,
    input  logic [DW-1:0] i_b,
    output logic [DW-1:0] o_y,
    output logic          o_ge
);

    logic [DW:0] sum;

    assign sum  = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {{DW{1'b0}}, i_sub};
    assign o_y  = sum[DW-1:0];
    assign o_ge = sum[DW];

endmodule

[hw/rtl/boundary_tag_first_fit_allocator_core.sv]
// Heap allocator core: boundary tag blocks in a word RAM, walked by a sequencer that drives
// one shared adder and one RAM read port. After reset the RAM is swept clear word by word
// (WORD_COUNT words, 8192 by default) and the first block is placed; no beat is taken
// meanwhile. An allocate walks from the heap start to the first free block that fits, marks
// it taken and splits it when enough is left; if nothing fits it adds a page while any is
// left and walks again. A free that fails its checks is rejected; any other free merges its
// block with free neighbours. A query walks every block. One beat is in work at a time; its
// result waits in the output register until taken, and the next beat is accepted after that.
module boundary_tag_first_fit_allocator_core #(
    parameter int HEAP_PAGES = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // request_size[23:0], payload_offset[40:24]
    input  logic [btffa_pkg::IN_TD_W-1:0]   i_s_axis_tdata,
    // kind[1:0]
    input  logic [btffa_pkg::KIND_W-1:0]    i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // result_offset[16:0], free_total[33:17]
    output logic [btffa_pkg::OUT_TD_W-1:0]  o_m_axis_tdata
);

    localparam int HEAP_BYTES = HEAP_PAGES * PAGE_BYTES;
    localparam int WORD_COUNT = HEAP_BYTES / 8;
    localparam int IW         = $clog2(WORD_COUNT);
    localparam int AW         = $clog2(HEAP_BYTES + 262144);
    localparam int DW         = (AW > btffa_pkg::SIZE_W) ? AW : btffa_pkg::SIZE_W;
    localparam int PW         = $clog2(HEAP_PAGES + 1);
    localparam int WW         = btffa_pkg::WORD_W;
    localparam logic [WW-1:0] PAGE_PAY = WW'(PAGE_BYTES - btffa_pkg::OVH_BYTES);

    typedef enum logic [43:0] {
        ST_CLR    = 44'd1 << 0,
        ST_INIT0  = 44'd1 << 1,
        ST_INIT1  = 44'd1 << 2,
        ST_IDLE   = 44'd1 << 3,
        ST_DONE   = 44'd1 << 4,
        ST_A0     = 44'd1 << 5,
        ST_WSTART = 44'd1 << 6,
        ST_WCHK   = 44'd1 << 7,
        ST_WRDU   = 44'd1 << 8,
        ST_WEVAL  = 44'd1 << 9,
        ST_WNX1   = 44'd1 << 10,
        ST_WNX2   = 44'd1 << 11,
        ST_FND0   = 44'd1 << 12,
        ST_SP0    = 44'd1 << 13,
        ST_SP1    = 44'd1 << 14,
        ST_SP2    = 44'd1 << 15,
        ST_SP3    = 44'd1 << 16,
        ST_SP4    = 44'd1 << 17,
        ST_FND5   = 44'd1 << 18,
        ST_FND6   = 44'd1 << 19,
        ST_EX0    = 44'd1 << 20,
        ST_EX1    = 44'd1 << 21,
        ST_F0     = 44'd1 << 22,
        ST_F1     = 44'd1 << 23,
        ST_F2     = 44'd1 << 24,
        ST_F3     = 44'd1 << 25,
        ST_F4     = 44'd1 << 26,
        ST_F5     = 44'd1 << 27,
        ST_F6     = 44'd1 << 28,
        ST_F7     = 44'd1 << 29,
        ST_F8     = 44'd1 << 30,
        ST_F9     = 44'd1 << 31,
        ST_F10    = 44'd1 << 32,
        ST_ML0    = 44'd1 << 33,
        ST_ML1    = 44'd1 << 34,
        ST_ML2    = 44'd1 << 35,
        ST_ML3    = 44'd1 << 36,
        ST_ML4    = 44'd1 << 37,
        ST_ML5    = 44'd1 << 38,
        ST_ML6    = 44'd1 << 39,
        ST_ML7    = 44'd1 << 40,
        ST_SS0    = 44'd1 << 41,
        ST_SS1    = 44'd1 << 42,
        ST_SS2    = 44'd1 << 43
    } t_state;

    t_state r_state, n_state, r_ret, r_mret;

    logic [IW-1:0]                     r_clr;
    logic [PW-1:0]                     r_pages;
    logic [AW-1:0]                     r_end, r_cur, r_h, r_t, r_fh, r_m, r_p;
    logic [WW-1:0]                     r_cs, r_v, r_rem, r_sum, r_res;
    logic [btffa_pkg::SIZE_W-1:0]      r_size;
    logic [btffa_pkg::KIND_W-1:0]      r_kind;
    logic [btffa_pkg::REQ_W-1:0]       r_req;
    logic [btffa_pkg::OFF_W-1:0]       r_off;
    logic                              r_oob;

    logic          alu_sub, alu_ge;
    logic [DW-1:0] alu_a, alu_b, alu_y;
    logic [AW-1:0] rd_addr, wa;
    logic          we, ram_we;
    logic [WW-1:0] wd, ram_wd, ram_q, rdata;
    logic [IW-1:0] ram_wi;
    logic          in_beat, is_alloc;

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign is_alloc = (r_kind == btffa_pkg::KIND_ALLOC);
    assign rdata    = r_oob ? '0 : ram_q;

    btffa_alu #(.DW(DW)) u_alu (
        .i_sub (alu_sub),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_y   (alu_y),
        .o_ge  (alu_ge)
    );

    assign ram_we = (r_state == ST_CLR) || (we && (wa < AW'(HEAP_BYTES)));
    assign ram_wi = (r_state == ST_CLR) ? r_clr : wa[IW+2:3];
    assign ram_wd = (r_state == ST_CLR) ? '0 : wd;

    btffa_ram #(.WIDTH(WW), .DEPTH(WORD_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wi),
        .i_wdata (ram_wd),
        .i_raddr (rd_addr[IW+2:3]),
        .o_rdata (ram_q)
    );

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        rd_addr = r_cur;
        we      = 1'b0;
        wa      = r_h;
        wd      = '0;
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_clr == IW'(WORD_COUNT - 1)) begin
                    n_state = ST_INIT0;
                end
            end
            ST_INIT0: begin
                we      = 1'b1;
                wa      = '0;
                wd      = PAGE_PAY;
                n_state = ST_INIT1;
            end
            ST_INIT1: begin
                we      = 1'b1;
                wa      = AW'(PAGE_BYTES - btffa_pkg::FTR_BYTES);
                wd      = PAGE_PAY;
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_beat) begin
                    unique case (i_s_axis_tuser)
                        btffa_pkg::KIND_ALLOC: n_state = ST_A0;
                        btffa_pkg::KIND_FREE:  n_state = ST_F0;
                        btffa_pkg::KIND_QUERY: n_state = ST_WSTART;
                        default:               n_state = ST_DONE;
                    endcase
                end
            end
            ST_DONE: begin
                if (i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_A0: begin
                alu_a   = DW'(r_req);
                alu_b   = DW'(btffa_pkg::ALIGN_ROUND);
                n_state = (r_req == '0) ? ST_DONE : ST_WSTART;
            end
            ST_WSTART: n_state = ST_WCHK;
            ST_WCHK: begin
                alu_a   = DW'(r_cur);
                alu_b   = DW'(r_end);
                alu_sub = 1'b1;
                rd_addr = r_cur;
                if (alu_ge) begin
                    n_state = is_alloc ? ST_EX0 : ST_DONE;
                end else begin
                    n_state = ST_WRDU;
                end
            end
            ST_WRDU: begin
                alu_a   = DW'(r_cur);
                alu_b   = DW'(btffa_pkg::FTR_BYTES);
                rd_addr = alu_y[AW-1:0];
                n_state = ST_WEVAL;
            end
            ST_WEVAL: begin
                if (is_alloc) begin
                    alu_a   = DW'(r_cs);
                    alu_b   = DW'(r_size);
                    alu_sub = 1'b1;
                    n_state = (rdata == '0 && alu_ge) ? ST_FND0 : ST_WNX1;
                end else begin
                    alu_a   = DW'(r_sum);
                    alu_b   = DW'(r_cs);
                    n_state = ST_WNX1;
                end
            end
            ST_WNX1: begin
                alu_a   = DW'(r_cur);
                alu_b   = DW'(r_cs);
                n_state = ST_WNX2;
            end
            ST_WNX2: begin
                alu_a   = DW'(r_cur);
                alu_b   = DW'(btffa_pkg::OVH_BYTES);
                n_state = ST_WCHK;
            end
            ST_FND0: begin
                alu_a   = DW'(r_rem);
                alu_b   = DW'(btffa_pkg::SPLIT_MIN);
                alu_sub = 1'b1;
                n_state = alu_ge ? ST_SP0 : ST_FND5;
            end
            ST_SP0: begin
                alu_a   = DW'(r_cur);
                alu_b   = DW'(r_size);
                n_state = ST_SP1;
            end
            ST_SP1: begin
                alu_a   = DW'(r_h);
                alu_b   = DW'(btffa_pkg::OVH_BYTES);
                n_state = ST_SP2;
            end
            ST_SP2: begin
                alu_a   = DW'(r_rem);
                alu_b   = DW'(btffa_pkg::OVH_BYTES);
                alu_sub = 1'b1;
                n_state = ST_SP3;
            end
            ST_SP3: begin
                alu_a   = DW'(r_h);
                alu_b   = DW'(btffa_pkg::FTR_BYTES);
                we      = 1'b1;
                wa      = alu_y[AW-1:0];
                n_state = ST_SS0;
            end
            ST_SP4:  n_state = ST_SS0;
            ST_FND5: begin
                alu_a   = DW'(r_cur);
                alu_b   = DW'(btffa_pkg::FTR_BYTES);
                we      = 1'b1;
                wa      = alu_y[AW-1:0];
                wd      = WW'(1);
                n_state = ST_FND6;
            end
            ST_FND6: begin
                alu_a   = DW'(r_cur);
                alu_b   = DW'(btffa_pkg::HDR_BYTES);
                n_state = ST_DONE;
            end
            ST_EX0: begin
                alu_a = DW'(r_end);
                alu_b = DW'(btffa_pkg::FTR_BYTES);
                if (r_pages >= PW'(HEAP_PAGES)) begin
                    n_state = ST_DONE;
                end else begin
                    we      = 1'b1;
                    wa      = alu_y[AW-1:0];
                    n_state = ST_SS0;
                end
            end
            ST_EX1: begin
                alu_a   = DW'(r_end);
                alu_b   = DW'(PAGE_BYTES);
                n_state = ST_ML0;
            end
            ST_F0: begin
                alu_a   = DW'(r_off);
                alu_b   = DW'(btffa_pkg::HDR_BYTES);
                alu_sub = 1'b1;
                if (r_off == '0 || r_off[2:0] != 3'd0 ||
                    r_off < btffa_pkg::OFF_W'(btffa_pkg::HDR_BYTES)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_F1;
                end
            end
            ST_F1: begin
                alu_a   = DW'(r_fh);
                alu_b   = DW'(r_end);
                alu_sub = 1'b1;
                n_state = alu_ge ? ST_DONE : ST_F2;
            end
            ST_F2: begin
                alu_a   = DW'(r_fh);
                alu_b   = DW'(btffa_pkg::FTR_BYTES);
                we      = 1'b1;
                wa      = alu_y[AW-1:0];
                n_state = ST_F3;
            end
            ST_F3: begin
                rd_addr = r_fh;
                n_state = ST_F4;
            end
            ST_F4: begin
                alu_a   = DW'(r_fh);
                alu_b   = DW'(rdata);
                n_state = ST_F5;
            end
            ST_F5: begin
                alu_a   = DW'(r_t);
                alu_b   = DW'(btffa_pkg::OVH_BYTES);
                n_state = ST_F6;
            end
            ST_F6: begin
                alu_a   = DW'(r_t);
                alu_b   = DW'(r_end);
                alu_sub = 1'b1;
                n_state = alu_ge ? ST_ML0 : ST_F7;
            end
            ST_F7: begin
                alu_a   = DW'(r_t);
                alu_b   = DW'(btffa_pkg::FTR_BYTES);
                rd_addr = alu_y[AW-1:0];
                n_state = ST_F8;
            end
            ST_F8: begin
                rd_addr = r_t;
                n_state = (rdata != '0) ? ST_ML0 : ST_F9;
            end
            ST_F9: begin
                alu_a   = DW'(r_cs);
                alu_b   = DW'(rdata);
                n_state = ST_F10;
            end
            ST_F10: begin
                alu_a   = DW'(r_v);
                alu_b   = DW'(btffa_pkg::OVH_BYTES);
                n_state = ST_SS0;
            end
            ST_ML0: begin
                alu_a   = DW'(r_m);
                alu_b   = DW'(btffa_pkg::FTR_BYTES);
                alu_sub = 1'b1;
                rd_addr = alu_y[AW-1:0];
                n_state = (r_m < AW'(btffa_pkg::FTR_BYTES)) ? r_mret : ST_ML1;
            end
            ST_ML1: begin
                alu_a   = DW'(rdata);
                alu_b   = DW'(btffa_pkg::OVH_BYTES);
                n_state = ST_ML2;
            end
            ST_ML2: begin
                alu_a   = DW'(r_m);
                alu_b   = DW'(r_t);
                alu_sub = 1'b1;
                n_state = alu_ge ? ST_ML3 : r_mret;
            end
            ST_ML3: begin
                alu_a   = DW'(r_p);
                alu_b   = DW'(btffa_pkg::FTR_BYTES);
                rd_addr = alu_y[AW-1:0];
                n_state = ST_ML4;
            end
            ST_ML4: begin
                rd_addr = r_p;
                n_state = (rdata != '0) ? r_mret : ST_ML5;
            end
            ST_ML5: begin
                rd_addr = r_m;
                n_state = ST_ML6;
            end
            ST_ML6: begin
                alu_a   = DW'(r_v);
                alu_b   = DW'(rdata);
                n_state = ST_ML7;
            end
            ST_ML7: begin
                alu_a   = DW'(r_v);
                alu_b   = DW'(btffa_pkg::OVH_BYTES);
                n_state = ST_SS0;
            end
            ST_SS0: begin
                we      = 1'b1;
                wa      = r_h;
                wd      = r_v;
                n_state = ST_SS1;
            end
            ST_SS1: begin
                alu_a   = DW'(r_h);
                alu_b   = DW'(r_v);
                n_state = ST_SS2;
            end
            ST_SS2: begin
                alu_a   = DW'(r_t);
                alu_b   = DW'(btffa_pkg::HDR_BYTES);
                we      = 1'b1;
                wa      = alu_y[AW-1:0];
                wd      = r_v;
                n_state = r_ret;
            end
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_oob <= (rd_addr >= AW'(HEAP_BYTES));
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_pages <= PW'(1);
            r_end   <= AW'(PAGE_BYTES);
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_CLR: r_clr <= r_clr + IW'(1);
                ST_IDLE: begin
                    if (in_beat) begin
                        r_kind <= i_s_axis_tuser;
                        r_req  <= i_s_axis_tdata[btffa_pkg::REQ_W-1:0];
                        r_off  <= i_s_axis_tdata[btffa_pkg::REQ_W +: btffa_pkg::OFF_W];
                        r_res  <= '0;
                        r_sum  <= '0;
                    end
                end
                ST_A0:     r_size <= {alu_y[btffa_pkg::SIZE_W-1:3], 3'b000};
                ST_WSTART: r_cur <= '0;
                ST_WRDU:   r_cs <= rdata;
                ST_WEVAL: begin
                    if (is_alloc) begin
                        r_rem <= alu_y[WW-1:0];
                    end else if (rdata == '0) begin
                        r_sum <= alu_y[WW-1:0];
                    end
                end
                ST_WNX1: r_cur <= alu_y[AW-1:0];
                ST_WNX2: r_cur <= alu_y[AW-1:0];
                ST_SP0:  r_h <= alu_y[AW-1:0];
                ST_SP1:  r_h <= alu_y[AW-1:0];
                ST_SP2:  r_v <= alu_y[WW-1:0];
                ST_SP3:  r_ret <= ST_SP4;
                ST_SP4: begin
                    r_h   <= r_cur;
                    r_v   <= r_size[WW-1:0];
                    r_ret <= ST_FND5;
                end
                ST_FND6: r_res <= alu_y[WW-1:0];
                ST_EX0: begin
                    r_h    <= r_end;
                    r_m    <= r_end;
                    r_mret <= ST_WSTART;
                    r_v    <= PAGE_PAY;
                    r_ret  <= ST_EX1;
                end
                ST_EX1: begin
                    r_end   <= alu_y[AW-1:0];
                    r_pages <= r_pages + PW'(1);
                end
                ST_F0: r_fh <= alu_y[AW-1:0];
                ST_F1: begin
                    r_m    <= r_fh;
                    r_mret <= ST_DONE;
                end
                ST_F4: begin
                    r_cs <= rdata;
                    r_t  <= alu_y[AW-1:0];
                end
                ST_F5:  r_t <= alu_y[AW-1:0];
                ST_F9:  r_v <= alu_y[WW-1:0];
                ST_F10: begin
                    r_v   <= alu_y[WW-1:0];
                    r_h   <= r_fh;
                    r_ret <= ST_ML0;
                end
                ST_ML1: r_t <= alu_y[AW-1:0];
                ST_ML2: r_p <= alu_y[AW-1:0];
                ST_ML5: r_v <= rdata;
                ST_ML6: r_v <= alu_y[WW-1:0];
                ST_ML7: begin
                    r_v   <= alu_y[WW-1:0];
                    r_h   <= r_p;
                    r_ret <= r_mret;
                end
                ST_SS1: r_t <= alu_y[AW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_DONE);
    assign o_m_axis_tdata  = {(btffa_pkg::OUT_TD_W - 2 * WW)'(0), r_sum, r_res};

endmodule

[hw/rtl/btffa_chk.sv]
// Port-level checker for the allocator core, bound to the core by the statement below.
// Depends on btffa_pkg and the shared assertion macro header.
`include "boundary_tag_first_fit_allocator_core_macros.svh"

module btffa_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [btffa_pkg::OUT_TD_W-1:0]  o_m_axis_tdata
);

    `BTFFA_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "Result beat dropped while stalled.")
    `BTFFA_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "Result beat changed while stalled.")
    `BTFFA_ASSERT_ALWAYS(a_no_accept_with_result, i_clk, i_rst_n, !(o_m_axis_tvalid && o_s_axis_tready), "Input accepted while a result is pending.")
    `BTFFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "Ready stayed high after a request beat.")
    `BTFFA_ASSERT_ALWAYS(a_one_field_set, i_clk, i_rst_n, !o_m_axis_tvalid || o_m_axis_tdata[16:0] == 17'd0 || o_m_axis_tdata[33:17] == 17'd0, "Offset and free total both set.")

endmodule

bind boundary_tag_first_fit_allocator_core btffa_chk u_btffa_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
